// ----- rtl/core/pacr_pkg.sv -----
// ----------------------------------------------------------------------------
// pacr_pkg: shared types and constants
// Sequencer states, phase and mode codes, register map and configuration.
// ----------------------------------------------------------------------------
package pacr_pkg;

  localparam int SET_FIELD_W  = 11;
  localparam int WAY_FIELD_W  = 4;
  localparam int ADDR_W       = 48;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int REUSE_W      = 3;

  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_STREAM  = 2'd1,
    PH_IRREG   = 2'd2
  } phase_e;

  typedef enum logic {
    MODE_VICTIM = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REG_STREAM_THR = 2'd0,
    REG_IRREG_THR  = 2'd1,
    REG_REUSE_LIM  = 2'd2,
    REG_SP_DIST    = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_HRD,
    ST_HSUB,
    ST_HABS,
    ST_HCMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic [4:0]         stream_thr;
    logic [4:0]         irreg_thr;
    logic [REUSE_W-1:0] reuse_lim;
    logic [11:0]        sp_dist;
  } cfg_t;

endpackage

// ----- rtl/core/pacr_ifs.sv -----
// ----------------------------------------------------------------------------
// pacr_ifs: request and response channels
// Valid/ready channels carrying event requests and victim responses.
// ----------------------------------------------------------------------------
interface pacr_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [10:0] set_index;
  logic [3:0]  way;
  logic [47:0] address;
  logic        hit;

  modport source (output valid, mode, set_index, way, address, hit, input ready);
  modport sink   (input valid, mode, set_index, way, address, hit, output ready);
endinterface

interface pacr_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_way;
  logic [1:0] phase;

  modport source (output valid, victim_way, phase, input ready);
  modport sink   (input valid, victim_way, phase, output ready);
endinterface

// ----- rtl/core/phase_adaptive_cache_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// phase_adaptive_cache_replacement_unit: phase-adaptive replacement policy
// Victim selection and access update for a set-associative cache.
// ----------------------------------------------------------------------------
// Victim request: set reduce, memory read (repeated when the set differs
//   from the last one read), scan at one way per cycle, decision; the
//   decision waits while an earlier response is not yet taken.
// Access update: same front end, then history entries through one shared
//   subtract unit (read plus three passes each), up to the first near entry.
// One transaction in flight; ready again right after the write-back.
// Reset: clearing pass over NUM_SETS rows, one per cycle, ready low meanwhile.
module phase_adaptive_cache_replacement_unit
  import pacr_pkg::*;
#(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // event and response channels
  pacr_req_if.sink          req_i,
  pacr_rsp_if.source        rsp_o
);

  cfg_t cfg;

  // thresholds, reuse limit, spatial distance
  pacr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: set memories, way scan, history search
  pacr_seq #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req    (req_i),
    .rsp    (rsp_o)
  );

endmodule

// ----- rtl/core/pacr_alu.sv -----
// ----------------------------------------------------------------------------
// pacr_alu: shared subtract/compare unit
// 48-bit subtraction with borrow; borrow set means a < b.
// ----------------------------------------------------------------------------
module pacr_alu
  import pacr_pkg::*;
(
  input  logic [ADDR_W-1:0] a_i,
  input  logic [ADDR_W-1:0] b_i,
  output logic [ADDR_W-1:0] diff_o,
  output logic              borrow_o
);

  logic [ADDR_W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[ADDR_W-1:0];
  assign borrow_o = full[ADDR_W];

endmodule

// ----- rtl/core/pacr_regs.sv -----
// ----------------------------------------------------------------------------
// pacr_regs: configuration registers
// APB-style write/read port holding the policy thresholds.
// ----------------------------------------------------------------------------
module pacr_regs
  import pacr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_STREAM_THR: cfg_d.stream_thr = pwdata[4:0];
        REG_IRREG_THR:  cfg_d.irreg_thr  = pwdata[4:0];
        REG_REUSE_LIM:  cfg_d.reuse_lim  = pwdata[REUSE_W-1:0];
        REG_SP_DIST:    cfg_d.sp_dist    = pwdata[11:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STREAM_THR: prdata = APB_DW'(cfg_q.stream_thr);
      REG_IRREG_THR:  prdata = APB_DW'(cfg_q.irreg_thr);
      REG_REUSE_LIM:  prdata = APB_DW'(cfg_q.reuse_lim);
      REG_SP_DIST:    prdata = APB_DW'(cfg_q.sp_dist);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stream_thr <= 5'd6;
      cfg_q.irreg_thr  <= 5'd3;
      cfg_q.reuse_lim  <= 3'd7;
      cfg_q.sp_dist    <= 12'd128;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/pacr_seq.sv -----
// ----------------------------------------------------------------------------
// pacr_seq: replacement sequencer
// Per-set state memories, way-by-way scan and history search driving the
// shared subtract unit.
// ----------------------------------------------------------------------------
module pacr_seq
  import pacr_pkg::*;
#(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  pacr_req_if.sink    req,
  pacr_rsp_if.source  rsp
);

  localparam int WW  = $clog2(NUM_WAYS);
  localparam int CW  = $clog2(NUM_WAYS + 1);
  localparam int SW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int HAW = (NUM_SETS * HISTORY_DEPTH > 1) ?
                       $clog2(NUM_SETS * HISTORY_DEPTH) : 1;
  // set reduce: quotient by reciprocal multiply, exact for 11-bit indexes
  localparam int MOD_L = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
  localparam int MOD_S = SET_FIELD_W + MOD_L;
  localparam int MOD_M = ((1 << MOD_S) + NUM_SETS - 1) / NUM_SETS;
  localparam int MW    = SET_FIELD_W + 2;
  localparam int PW    = SET_FIELD_W + MW;

  typedef struct packed {
    logic [WW-1:0]      rec;
    logic [REUSE_W-1:0] reuse;
    logic               sp;
  } way_t;
  typedef way_t [NUM_WAYS-1:0] row_t;

  typedef struct packed {
    logic [1:0]     phase;
    logic [FW-1:0]  fill;
    logic [HIW-1:0] head;
  } meta_t;

  // storage
  row_t              row_mem  [NUM_SETS];
  meta_t             meta_mem [NUM_SETS];
  logic [ADDR_W-1:0] hist_mem [NUM_SETS * HISTORY_DEPTH];

  row_t              row_rd_q;
  meta_t             meta_rd_q;
  logic [ADDR_W-1:0] hist_rd_q;

  logic              row_we, hist_we;
  logic [SW-1:0]     row_wa;
  row_t              row_wd;
  meta_t             meta_wd;
  logic [HAW-1:0]    hist_ra, hist_wa;

  state_e            state_q, state_d;
  logic [SW-1:0]     clr_q, clr_d;
  logic [SW-1:0]     set_q, set_d;
  logic [SET_FIELD_W-1:0] raw_q, raw_d;
  logic [SET_FIELD_W-1:0] rem_q, rem_d;
  logic              mode_q, mode_d;
  logic [WAY_FIELD_W-1:0] way_q, way_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              hit_q, hit_d;
  row_t              row_q, row_d;
  meta_t             meta_q, meta_d;
  logic [WW-1:0]     wi_q, wi_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              s_fnd_q, s_fnd_d, i_fnd_q, i_fnd_d, l_fnd_q, l_fnd_d;
  logic [WW-1:0]     s_vic_q, s_vic_d, s_old_q, s_old_d;
  logic [WW-1:0]     i_vic_q, i_vic_d, i_old_q, i_old_d;
  logic [REUSE_W-1:0] i_best_q, i_best_d;
  logic [WW-1:0]     l_vic_q, l_vic_d;
  logic [FW-1:0]     hi_q, hi_d;
  logic [ADDR_W-1:0] diff_q, diff_d;
  logic              brw_q, brw_d;
  logic              near_q, near_d;
  logic              ovld_q, ovld_d;
  logic [3:0]        ovic_q, ovic_d;
  logic [1:0]        oph_q, oph_d;

  // shared unit
  logic [ADDR_W-1:0] alu_a, alu_b, alu_diff;
  logic              alu_brw;
  logic [PW-1:0]          mod_prod;
  logic [SET_FIELD_W-1:0] mod_quo, mod_rem;

  pacr_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_brw)
  );

  assign mod_prod = PW'(raw_q) * PW'(MOD_M);
  assign mod_quo  = SET_FIELD_W'(mod_prod >> MOD_S);
  assign mod_rem  = raw_q - SET_FIELD_W'(mod_quo * NUM_SETS);

  always_comb begin
    case (state_q)
      ST_HSUB: begin alu_a = addr_q;          alu_b = hist_rd_q;         end
      ST_HABS: begin
        alu_a = brw_q ? hist_rd_q : addr_q;
        alu_b = brw_q ? addr_q : hist_rd_q;
      end
      ST_HCMP: begin alu_a = ADDR_W'(cfg_i.sp_dist); alu_b = diff_q; end
      default: begin alu_a = '0; alu_b = '0; end
    endcase
  end

  assign hist_ra = HAW'(set_q) * HAW'(HISTORY_DEPTH) + HAW'(hi_q[HIW-1:0]);

  // memories
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa]  <= row_wd;
      meta_mem[row_wa] <= meta_wd;
    end
    row_rd_q  <= row_mem[set_q];
    meta_rd_q <= meta_mem[set_q];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= addr_q;
    hist_rd_q <= hist_mem[hist_ra];
  end

  // scan helpers
  way_t          cur;
  logic [CW-1:0] nsp;
  logic [1:0]    ph;
  logic [WW-1:0] vic;
  logic [WW-1:0] upd_w, old_rec;
  logic [REUSE_W:0] u1;
  logic [HIW-1:0] wptr;

  assign cur   = row_q[wi_q];
  assign nsp   = CW'(NUM_WAYS) - cnt_q;
  assign upd_w = WW'(way_q);
  assign old_rec = row_q[upd_w].rec;
  assign u1    = {1'b0, row_q[upd_w].reuse} + 1'b1;
  assign wptr  = (meta_q.fill < FW'(HISTORY_DEPTH)) ? HIW'(meta_q.fill) : meta_q.head;

  always_comb begin
    if (7'(nsp) >= 7'(cfg_i.stream_thr))     ph = PH_STREAM;
    else if (7'(cnt_q) >= 7'(cfg_i.irreg_thr)) ph = PH_IRREG;
    else                                      ph = PH_UNKNOWN;
    if (ph == PH_STREAM && s_fnd_q)      vic = s_vic_q;
    else if (ph == PH_IRREG && i_fnd_q)  vic = i_vic_q;
    else if (l_fnd_q)                    vic = l_vic_q;
    else                                 vic = '0;
  end

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  set_d = set_q;  raw_d = raw_q;
    rem_d = rem_q;      mode_d = mode_q; way_d = way_q;
    addr_d = addr_q;    hit_d = hit_q;  row_d = row_q;  meta_d = meta_q;
    wi_d = wi_q;        cnt_d = cnt_q;
    s_fnd_d = s_fnd_q;  s_vic_d = s_vic_q; s_old_d = s_old_q;
    i_fnd_d = i_fnd_q;  i_vic_d = i_vic_q; i_old_d = i_old_q; i_best_d = i_best_q;
    l_fnd_d = l_fnd_q;  l_vic_d = l_vic_q;
    hi_d = hi_q;        diff_d = diff_q; brw_d = brw_q;   near_d = near_q;
    ovld_d = ovld_q;    ovic_d = ovic_q; oph_d = oph_q;
    row_we = 1'b0;      row_wa = set_q;  row_wd = row_q;  meta_wd = meta_q;
    hist_we = 1'b0;
    hist_wa = HAW'(set_q) * HAW'(HISTORY_DEPTH) + HAW'(wptr);
    req.ready = 1'b0;

    if (rsp.ready) ovld_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        row_we  = 1'b1;
        row_wa  = clr_q;
        meta_wd = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          row_wd[w].rec   = WW'(w);
          row_wd[w].reuse = '0;
          row_wd[w].sp    = 1'b0;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == SW'(NUM_SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          mode_d = req.mode;
          raw_d  = req.set_index;
          way_d  = req.way;
          addr_d = req.address;
          hit_d  = req.hit;
          // update naming a missing way is dropped
          if (!(req.mode == MODE_UPDATE && 6'(req.way) >= 6'(NUM_WAYS)))
            state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        rem_d   = mod_rem;
        state_d = ST_RD;
      end
      ST_RD: begin
        set_d = SW'(rem_q);
        if (set_q == SW'(rem_q)) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        row_d   = row_rd_q;
        meta_d  = meta_rd_q;
        wi_d    = '0;   cnt_d = '0;
        s_fnd_d = 1'b0; s_old_d = '0;  s_vic_d = '0;
        i_fnd_d = 1'b0; i_old_d = '0;  i_vic_d = '0; i_best_d = '0;
        l_fnd_d = 1'b0; l_vic_d = '0;
        hi_d    = '0;   near_d = 1'b0;
        if (mode_q == MODE_VICTIM)  state_d = ST_SCAN;
        else if (meta_rd_q.fill == '0) state_d = ST_UPD;
        else                          state_d = ST_HRD;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CW'(cur.sp);
        if (!cur.sp && cur.reuse <= 3'd1 && cur.rec >= s_old_q) begin
          s_vic_d = wi_q; s_old_d = cur.rec; s_fnd_d = 1'b1;
        end
        if (!i_fnd_q || cur.reuse < i_best_q ||
            (cur.reuse == i_best_q && cur.rec > i_old_q)) begin
          i_vic_d = wi_q; i_best_d = cur.reuse; i_old_d = cur.rec; i_fnd_d = 1'b1;
        end
        if (!l_fnd_q && cur.rec == WW'(NUM_WAYS - 1)) begin
          l_vic_d = wi_q; l_fnd_d = 1'b1;
        end
        wi_d = wi_q + 1'b1;
        if (wi_q == WW'(NUM_WAYS - 1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!ovld_q || rsp.ready) begin
          ovld_d        = 1'b1;
          ovic_d        = 4'(vic);
          oph_d         = ph;
          row_we        = 1'b1;
          meta_wd.phase = ph;
          state_d       = ST_IDLE;
        end
      end
      ST_HRD:  state_d = ST_HSUB;
      ST_HSUB: begin
        diff_d  = alu_diff;
        brw_d   = alu_brw;
        state_d = ST_HABS;
      end
      ST_HABS: begin
        diff_d  = alu_diff;
        state_d = ST_HCMP;
      end
      ST_HCMP: begin
        hi_d = hi_q + 1'b1;
        if (!alu_brw) begin
          near_d  = 1'b1;
          state_d = ST_UPD;
        end else if (hi_q == meta_q.fill - 1'b1) begin
          state_d = ST_UPD;
        end else begin
          state_d = ST_HRD;
        end
      end
      ST_UPD: begin
        for (int w = 0; w < NUM_WAYS; w++)
          if (row_q[w].rec < old_rec) row_wd[w].rec = row_q[w].rec + 1'b1;
        row_wd[upd_w].rec = (meta_q.phase == PH_STREAM && !hit_q) ?
                            WW'(NUM_WAYS - 1) : '0;
        if (!hit_q)                          row_wd[upd_w].reuse = '0;
        else if (u1 > {1'b0, cfg_i.reuse_lim}) row_wd[upd_w].reuse = cfg_i.reuse_lim;
        else                                 row_wd[upd_w].reuse = u1[REUSE_W-1:0];
        row_wd[upd_w].sp = near_q;
        if (meta_q.fill < FW'(HISTORY_DEPTH)) begin
          meta_wd.fill = meta_q.fill + 1'b1;
        end else if (meta_q.head == HIW'(HISTORY_DEPTH - 1)) begin
          meta_wd.head = '0;
        end else begin
          meta_wd.head = meta_q.head + 1'b1;
        end
        row_we  = 1'b1;
        hist_we = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;   raw_q <= raw_d;   rem_q <= rem_d;
    mode_q <= mode_d; way_q <= way_d;   addr_q <= addr_d; hit_q <= hit_d;
    row_q <= row_d;   meta_q <= meta_d; wi_q <= wi_d;     cnt_q <= cnt_d;
    s_fnd_q <= s_fnd_d; s_vic_q <= s_vic_d; s_old_q <= s_old_d;
    i_fnd_q <= i_fnd_d; i_vic_q <= i_vic_d; i_old_q <= i_old_d;
    i_best_q <= i_best_d;
    l_fnd_q <= l_fnd_d; l_vic_q <= l_vic_d;
    hi_q <= hi_d;     diff_q <= diff_d; brw_q <= brw_d;   near_q <= near_d;
    ovic_q <= ovic_d; oph_q <= oph_d;
  end

  assign rsp.valid      = ovld_q;
  assign rsp.victim_way = ovic_q;
  assign rsp.phase      = oph_q;

endmodule

// ----- sim/phase_adaptive_cache_replacement_unit_checker.sv -----
// ----------------------------------------------------------------------------
// phase_adaptive_cache_replacement_unit_checker: victim prediction and compare
// Watches the event, response and register channels, keeps its own copy of
// the replacement state and compares every victim response with it.
// ----------------------------------------------------------------------------
module phase_adaptive_cache_replacement_unit_checker
  import pacr_pkg::*;
#(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  pacr_req_if.sink          req_i,
  pacr_rsp_if.sink          rsp_i,
  output int                errors_o,
  output int                pending_o,
  output int                victims_o
);

  typedef struct packed {
    logic [3:0] victim_way;
    phase_e     phase;
  } victim_t;

  logic [3:0]        lru_rank [NUM_SETS][NUM_WAYS];
  logic [REUSE_W-1:0] reuse   [NUM_SETS][NUM_WAYS];
  logic              near     [NUM_SETS][NUM_WAYS];
  logic [ADDR_W-1:0] hist     [NUM_SETS][HISTORY_DEPTH];
  int                hist_len [NUM_SETS];
  phase_e            stored_ph[NUM_SETS];
  cfg_t              cfg;
  victim_t           victim_q[$];

  function automatic victim_t pick_victim(int s);
    int sp, nsp, oldest, best;
    bit found;
    phase_e ph;
    victim_t v;
    sp = 0; nsp = 0; found = 0; oldest = 0; best = 0;
    v.victim_way = 0;
    for (int w = 0; w < NUM_WAYS; w++) if (near[s][w]) sp++; else nsp++;
    if (nsp >= cfg.stream_thr) ph = PH_STREAM;
    else if (sp >= cfg.irreg_thr) ph = PH_IRREG;
    else ph = PH_UNKNOWN;
    stored_ph[s] = ph;
    if (ph == PH_STREAM) begin
      for (int w = 0; w < NUM_WAYS; w++)
        if (!near[s][w] && reuse[s][w] <= 1 && lru_rank[s][w] >= oldest) begin
          v.victim_way = 4'(w); oldest = lru_rank[s][w]; found = 1;
        end
    end else if (ph == PH_IRREG) begin
      for (int w = 0; w < NUM_WAYS; w++)
        if (!found || reuse[s][w] < best ||
            (reuse[s][w] == best && lru_rank[s][w] > oldest)) begin
          v.victim_way = 4'(w); best = reuse[s][w]; oldest = lru_rank[s][w]; found = 1;
        end
    end
    if (!found) begin
      v.victim_way = 0;
      for (int w = NUM_WAYS - 1; w >= 0; w--)
        if (lru_rank[s][w] == NUM_WAYS - 1) v.victim_way = 4'(w);
    end
    v.phase = ph;
    return v;
  endfunction

  task automatic apply_access(int s, int way, logic [ADDR_W-1:0] a, logic hit);
    logic [ADDR_W-1:0] d;
    logic close;
    int prev;
    close = 0;
    for (int i = 0; i < hist_len[s]; i++) begin
      d = (a > hist[s][i]) ? a - hist[s][i] : hist[s][i] - a;
      if (d <= cfg.sp_dist) close = 1;
    end
    // history keeps the newest entries, oldest shifted out
    if (hist_len[s] >= HISTORY_DEPTH) begin
      for (int i = 1; i < HISTORY_DEPTH; i++) hist[s][i-1] = hist[s][i];
      hist[s][HISTORY_DEPTH-1] = a;
    end else begin
      hist[s][hist_len[s]] = a;
      hist_len[s]++;
    end
    prev = lru_rank[s][way];
    for (int w = 0; w < NUM_WAYS; w++) if (lru_rank[s][w] < prev) lru_rank[s][w]++;
    lru_rank[s][way] = 0;
    if (hit) reuse[s][way] = (reuse[s][way] >= cfg.reuse_lim) ? cfg.reuse_lim :
                             REUSE_W'(reuse[s][way] + 1'b1);
    else reuse[s][way] = 0;
    near[s][way] = close;
    // streaming miss goes in at the LRU end, others untouched
    if (stored_ph[s] == PH_STREAM && !hit) lru_rank[s][way] = 4'(NUM_WAYS - 1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    victim_t got, want;
    int s;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          lru_rank[i][w] = 4'(w); reuse[i][w] = 0; near[i][w] = 0;
        end
        hist_len[i] = 0;
        stored_ph[i] = PH_UNKNOWN;
      end
      cfg = '{stream_thr: 5'd6, irreg_thr: 5'd3, reuse_lim: 3'd7, sp_dist: 12'd128};
      victim_q.delete();
      errors_o = 0;
      victims_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_STREAM_THR: cfg.stream_thr = pwdata[4:0];
          REG_IRREG_THR:  cfg.irreg_thr  = pwdata[4:0];
          REG_REUSE_LIM:  cfg.reuse_lim  = pwdata[2:0];
          REG_SP_DIST:    cfg.sp_dist    = pwdata[11:0];
          default:        ;
        endcase
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.victim_way = rsp_i.victim_way;
        got.phase = phase_e'(rsp_i.phase);
        victims_o++;
        if (victim_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected response way %0d phase %0d",
                                       got.victim_way, got.phase);
        end else begin
          want = victim_q.pop_front();
          if (got.victim_way !== want.victim_way || got.phase !== want.phase) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: way exp %0d got %0d, phase exp %0d got %0d",
                       want.victim_way, got.victim_way, want.phase, got.phase);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        s = req_i.set_index % NUM_SETS;
        if (mode_e'(req_i.mode) == MODE_VICTIM) victim_q = {victim_q, pick_victim(s)};
        else if (req_i.way < NUM_WAYS)
          apply_access(s, req_i.way, req_i.address, req_i.hit);
      end
    end
    pending_o = victim_q.size();
  end

endmodule

// ----- sim/phase_adaptive_cache_replacement_unit_test.sv -----
// ----------------------------------------------------------------------------
// phase_adaptive_cache_replacement_unit_test: top of the replacement testbench
// Drives events and register writes, throttles the response side and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module phase_adaptive_cache_replacement_unit_test;
  import pacr_pkg::*;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                errors, pending, victims;
  int                send_idle_pct = 0;   // chance of a sender gap per cycle
  int                recv_idle_pct = 0;   // chance of a receiver stall per cycle
  int                hold_cycles = 0;     // long receiver hold-off when nonzero
  int                n_events = 0;

  pacr_req_if req();
  pacr_rsp_if rsp();

  phase_adaptive_cache_replacement_unit uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_i(req.sink), .rsp_o(rsp.source)
  );

  phase_adaptive_cache_replacement_unit_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .req_i(req.sink), .rsp_i(rsp.sink),
    .errors_o(errors), .pending_o(pending), .victims_o(victims)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req.valid = 0; req.mode = 0; req.set_index = 0; req.way = 0;
    req.address = 0; req.hit = 0;
    rsp.ready = 0;
  end

  // response side: random stalls, plus a counted long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp.ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // register write: setup then access phase
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_config(int st, int it, int rl, int sd);
    write_reg(REG_STREAM_THR, st);
    write_reg(REG_IRREG_THR, it);
    write_reg(REG_REUSE_LIM, rl);
    write_reg(REG_SP_DIST, sd);
  endtask

  // wait for all victims to come back, then cover an update still in flight
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // offer one event, with an optional random gap before it
  task automatic send_event(mode_e m, int s, int w, logic [47:0] a, logic h);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(posedge clk_i);
    end
    req.valid <= 1; req.mode <= m; req.set_index <= 11'(s); req.way <= 4'(w);
    req.address <= a; req.hit <= h;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    n_events++;
  endtask

  task automatic idle_req();
    req.valid <= 0;
    @(posedge clk_i);
  endtask

  // mostly a few hot sets with clustered addresses so history and marks matter
  task automatic random_events(int n);
    int s;
    logic [47:0] a;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(3);
      if ($urandom_range(3) == 0) a = 48'({$urandom(), $urandom()});
      else a = 48'h0000_1000_0000 + s * 48'h10000 + $urandom_range(1023);
      if ($urandom_range(2) == 0) send_event(MODE_VICTIM, s, $urandom_range(15), a, 0);
      else send_event(MODE_UPDATE, s, $urandom_range(15), a, 1'($urandom_range(1)));
    end
    idle_req();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: defaults, field extremes, spatial marking, saturation, streaming
    send_event(MODE_VICTIM, 0, 0, 0, 0);
    send_event(MODE_VICTIM, 2047, 15, 48'hFFFF_FFFF_FFFF, 1);
    send_event(MODE_UPDATE, 5, 15, 48'hFFFF_FFFF_FFFF, 1);
    send_event(MODE_UPDATE, 5, 15, 48'hFFFF_FFFF_FF7F, 1);  // exactly at distance
    send_event(MODE_UPDATE, 5, 3, 48'hFFFF_FFFF_FEFE, 1);   // just past it
    for (int i = 0; i < 9; i++) send_event(MODE_UPDATE, 5, 7, 48'h100 + i, 1);
    send_event(MODE_VICTIM, 5, 0, 0, 0);
    send_event(MODE_UPDATE, 5, 9, 48'h120, 0);   // streaming miss to LRU end
    send_event(MODE_VICTIM, 5, 0, 0, 0);
    send_event(MODE_UPDATE, 2047, 0, 48'h0, 0);
    send_event(MODE_VICTIM, 2047, 0, 0, 0);
    idle_req();
    drain();

    // extremes of the registers
    set_config(16, 16, 0, 4095);
    send_idle_pct = 11; recv_idle_pct = 54;
    random_events(250);
    drain();
    set_config(0, 0, 7, 0);
    random_events(250);
    drain();
    set_config(31, 1, 1, 2048);
    send_idle_pct = 54; recv_idle_pct = 11;
    random_events(300);
    drain();

    // receiver held off long enough for requests to back up
    set_config(12, 5, 3, 300);
    hold_cycles = 2000;
    random_events(150);
    // sender pauses until everything has come back
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_config(6, 3, 7, 128);
    random_events(530);
    drain();

    $display("covered %0d events, %0d victim responses over 6 register settings",
             n_events, victims);
    if (errors == 0) $display("phase_adaptive_cache_replacement_unit verification clean");
    else $display("phase_adaptive_cache_replacement_unit verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("phase_adaptive_cache_replacement_unit verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pacr_pkg.sv
rtl/core/pacr_ifs.sv
rtl/core/pacr_alu.sv
rtl/core/pacr_regs.sv
rtl/core/pacr_seq.sv
rtl/core/phase_adaptive_cache_replacement_unit.sv
sim/phase_adaptive_cache_replacement_unit_checker.sv
sim/phase_adaptive_cache_replacement_unit_test.sv
